// ===== design/hermite_force_jerk_all_pairs_unit_assert.svh =====
// assertion macros for the n-body force and jerk unit
// each macro expects clk and rst_n in the scope where it is used
`ifndef HERMITE_FORCE_JERK_ALL_PAIRS_UNIT_ASSERT_SVH
`define HERMITE_FORCE_JERK_ALL_PAIRS_UNIT_ASSERT_SVH

// same-cycle implication
`define HFJAP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfjap assertion failed");

// next-cycle implication
`define HFJAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfjap assertion failed");

`endif

// ===== design/hfjap_pkg.sv =====
// ----------------------------------------------------------------------------
// hfjap_pkg
// shared types, commands and the inverse square root seed table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfjap_pkg;

    localparam int MAX_BODIES_DEF = 16;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_SELF,
        OP_DIFF,
        OP_SQ,
        OP_ZERO_HIT,
        OP_NORM_INIT,
        OP_NORM_STEP,
        OP_NEWT_SQ,
        OP_NEWT_Q,
        OP_NEWT_Y,
        OP_CUBE,
        OP_MASS,
        OP_UNIT,
        OP_DOT,
        OP_WVEC,
        OP_ACC,
        OP_JERK,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] comp;
        logic       last;
        logic [3:0] index;
    } cmd_t;

    typedef struct packed {
        logic r_zero;
        logic norm_ok;
    } sts_t;

    // one stored body
    typedef struct packed {
        logic [31:0]      mass;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] pos;
    } body_row_t;

    // q1.31 seed of 1/sqrt(x), indexed by the top four bits of a q2.30 value
    function automatic logic [31:0] seed_lookup(input logic [3:0] idx);
        logic [31:0] val;
        case (idx)
            4'd4:    val = 32'd2024667000;
            4'd5:    val = 32'd1831380000;
            4'd6:    val = 32'd1684625000;
            4'd7:    val = 32'd1568300000;
            4'd8:    val = 32'd1473162000;
            4'd9:    val = 32'd1393471000;
            4'd10:   val = 32'd1325456000;
            4'd11:   val = 32'd1266517000;
            4'd12:   val = 32'd1214800000;
            4'd13:   val = 32'd1168942000;
            4'd14:   val = 32'd1127914000;
            4'd15:   val = 32'd1090923000;
            default: val = 32'd2147483648;
        endcase
        return val;
    endfunction

endpackage

// ===== design/hfjap_ctrl.sv =====
// ----------------------------------------------------------------------------
// hfjap_ctrl
// load counter and pair sequencer, issues one datapath command per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfjap_ctrl #(
    parameter int MAX_BODIES = hfjap_pkg::MAX_BODIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          last_body,
    output logic                          busy,
    output logic                          result_valid,
    input  hfjap_pkg::sts_t               sts,
    output hfjap_pkg::cmd_t               cmd,
    output logic                          mem_we,
    output logic                          mem_re,
    output logic [$clog2(MAX_BODIES)-1:0] wr_addr,
    output logic [$clog2(MAX_BODIES)-1:0] rd_addr
);

    localparam int CW = $clog2(MAX_BODIES + 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_I,
        S_LATCH_I,
        S_RD_J,
        S_DIFF,
        S_SQ,
        S_ZCHK,
        S_NORM,
        S_NEWT_SQ,
        S_NEWT_Q,
        S_NEWT_Y,
        S_CUBE_SQ,
        S_CUBE,
        S_MASS,
        S_UNIT,
        S_DOT,
        S_WVEC,
        S_ACC,
        S_JERK,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [1:0]      comp_reg, comp_next;
    logic            newt_reg, newt_next;
    logic            valid_reg, valid_next;
    logic [CW+3:0]   i_wide;
    logic            accept;
    logic            i_last;

    assign i_wide       = {4'b0, i_reg};
    assign accept       = start && (state_reg == S_IDLE);
    assign i_last       = (CW'(i_reg + 1'b1) == count_reg);
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign wr_addr      = count_reg[$clog2(MAX_BODIES)-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        comp_next  = comp_reg;
        newt_next  = newt_reg;
        valid_next = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        rd_addr    = i_reg[$clog2(MAX_BODIES)-1:0];
        cmd.op     = hfjap_pkg::OP_NONE;
        cmd.comp   = comp_reg;
        cmd.last   = i_last;
        cmd.index  = i_wide[3:0];

        // step through the components, then move on
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CW'(MAX_BODIES))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (last_body)
                    begin
                        i_next     = '0;
                        state_next = S_RD_I;
                    end
                end
            end
            S_RD_I:
            begin
                mem_re     = 1'b1;
                state_next = S_LATCH_I;
            end
            S_LATCH_I:
            begin
                cmd.op     = hfjap_pkg::OP_LOAD_SELF;
                j_next     = '0;
                state_next = S_RD_J;
            end
            S_RD_J:
            begin
                rd_addr = j_reg[$clog2(MAX_BODIES)-1:0];
                if (j_reg == count_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.op     = hfjap_pkg::OP_DIFF;
                comp_next  = 2'd0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op = hfjap_pkg::OP_SQ;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = S_ZCHK;
                end
                else
                begin
                    comp_next = comp_reg + 1'b1;
                end
            end
            S_ZCHK:
            begin
                if (sts.r_zero)
                begin
                    cmd.op     = hfjap_pkg::OP_ZERO_HIT;
                    j_next     = j_reg + 1'b1;
                    state_next = S_RD_J;
                end
                else
                begin
                    cmd.op     = hfjap_pkg::OP_NORM_INIT;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.op = hfjap_pkg::OP_NORM_STEP;
                if (sts.norm_ok)
                begin
                    newt_next  = 1'b0;
                    state_next = S_NEWT_SQ;
                end
            end
            S_NEWT_SQ:
            begin
                cmd.op     = hfjap_pkg::OP_NEWT_SQ;
                state_next = S_NEWT_Q;
            end
            S_NEWT_Q:
            begin
                cmd.op     = hfjap_pkg::OP_NEWT_Q;
                state_next = S_NEWT_Y;
            end
            S_NEWT_Y:
            begin
                cmd.op = hfjap_pkg::OP_NEWT_Y;
                if (newt_reg)
                begin
                    state_next = S_CUBE_SQ;
                end
                else
                begin
                    newt_next  = 1'b1;
                    state_next = S_NEWT_SQ;
                end
            end
            S_CUBE_SQ:
            begin
                cmd.op     = hfjap_pkg::OP_NEWT_SQ;
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                cmd.op     = hfjap_pkg::OP_CUBE;
                state_next = S_MASS;
            end
            S_MASS:
            begin
                cmd.op     = hfjap_pkg::OP_MASS;
                comp_next  = 2'd0;
                state_next = S_UNIT;
            end
            S_UNIT, S_DOT, S_WVEC, S_ACC, S_JERK:
            begin
                case (state_reg)
                    S_UNIT:  cmd.op = hfjap_pkg::OP_UNIT;
                    S_DOT:   cmd.op = hfjap_pkg::OP_DOT;
                    S_WVEC:  cmd.op = hfjap_pkg::OP_WVEC;
                    S_ACC:   cmd.op = hfjap_pkg::OP_ACC;
                    default: cmd.op = hfjap_pkg::OP_JERK;
                endcase
                if (comp_reg == 2'd2)
                begin
                    comp_next = 2'd0;
                    case (state_reg)
                        S_UNIT:  state_next = S_DOT;
                        S_DOT:   state_next = S_WVEC;
                        S_WVEC:  state_next = S_ACC;
                        S_ACC:   state_next = S_JERK;
                        default:
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = S_RD_J;
                        end
                    endcase
                end
                else
                begin
                    comp_next = comp_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                cmd.op     = hfjap_pkg::OP_EMIT;
                valid_next = 1'b1;
                if (i_last)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RD_I;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            comp_reg  <= '0;
            newt_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            comp_reg  <= comp_next;
            newt_reg  <= newt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== design/hfjap_datapath.sv =====
// ----------------------------------------------------------------------------
// hfjap_datapath
// body memory, one shared multiplier with shift and clamp, sum registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfjap_datapath #(
    parameter int MAX_BODIES = hfjap_pkg::MAX_BODIES_DEF
) (
    input  logic                          clk,
    input  hfjap_pkg::cmd_t               cmd,
    input  logic                          mem_we,
    input  logic                          mem_re,
    input  logic [$clog2(MAX_BODIES)-1:0] wr_addr,
    input  logic [$clog2(MAX_BODIES)-1:0] rd_addr,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic signed [31:0]            vel_x,
    input  logic signed [31:0]            vel_y,
    input  logic signed [31:0]            vel_z,
    input  logic [31:0]                   mass,
    output hfjap_pkg::sts_t               sts,
    output logic [3:0]                    body_index,
    output logic signed [47:0]            acc_x,
    output logic signed [47:0]            acc_y,
    output logic signed [47:0]            acc_z,
    output logic signed [47:0]            jerk_x,
    output logic signed [47:0]            jerk_y,
    output logic signed [47:0]            jerk_z,
    output logic                          saturated,
    output logic                          last_result
);

    localparam int ACC_W = 49 + $clog2(MAX_BODIES);
    localparam logic [33:0] THREE_Q31 = 34'h1_8000_0000;

    function automatic logic [40:0] mag41(input logic signed [40:0] x);
        return x[40] ? 41'(-x) : 41'(x);
    endfunction

    // {clamped, value} of a sum held to 48 bits
    function automatic logic [48:0] clamp48(input logic signed [ACC_W-1:0] x);
        logic [48:0] res;
        if ((x[ACC_W-1:47] == '0) || (x[ACC_W-1:47] == '1))
            res = {1'b0, x[47:0]};
        else if (x[ACC_W-1])
            res = {1'b1, 48'h8000_0000_0000};
        else
            res = {1'b1, 48'h7FFF_FFFF_FFFF};
        return res;
    endfunction

    hfjap_pkg::body_row_t mem [MAX_BODIES];
    hfjap_pkg::body_row_t row_reg;
    hfjap_pkg::body_row_t wr_row;

    logic [2:0][31:0]          self_pos_reg;
    logic [2:0][31:0]          self_vel_reg;
    logic signed [32:0]        r_reg [3];
    logic signed [32:0]        v_reg [3];
    logic signed [32:0]        u_reg [3];
    logic signed [40:0]        w_reg [3];
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic signed [ACC_W-1:0]   jrk_reg [3];
    logic [31:0]               mj_reg;
    logic [65:0]               rsq_reg;
    logic [65:0]               nrm_reg;
    logic signed [5:0]         s_reg;
    logic [31:0]               xm_reg;
    logic [31:0]               y_reg;
    logic [31:0]               y2_reg;
    logic [32:0]               t_reg;
    logic [31:0]               y3_reg;
    logic [32:0]               my_reg;
    logic signed [35:0]        dot_reg;
    logic                      sat_reg;

    logic signed [32:0]        r_sel, v_sel, u_sel;
    logic signed [40:0]        w_sel;
    logic [32:0]               r_mag, v_mag, u_mag;
    logic [40:0]               w_mag, dot_mag;
    logic [40:0]               mul_a;
    logic [32:0]               mul_b;
    logic                      neg;
    logic [73:0]               prod;
    logic signed [7:0]         s_ext, unit_amt, term_amt;
    logic [6:0]                shf_amt;
    logic [105:0]              shf_out;
    logic                      unit_over, term_over;
    logic [32:0]               unit_mag;
    logic signed [32:0]        unit_val;
    logic [46:0]               term_mag;
    logic signed [ACC_W-1:0]   term_pos, term_val;
    logic signed [35:0]        dot_term, dot_val;
    logic [75:0]               p3;
    logic signed [40:0]        w_term, w_val;
    logic [33:0]               q_val;
    logic [32:0]               t_val;
    logic [41:0]               y_raw;
    logic [31:0]               y_val;
    logic [48:0]               acc_cl [3];
    logic [48:0]               jrk_cl [3];
    logic                      any_clamp;

    assign wr_row.pos  = {pos_z, pos_y, pos_x};
    assign wr_row.vel  = {vel_z, vel_y, vel_x};
    assign wr_row.mass = mass;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_row;
        if (mem_re)
            row_reg <= mem[rd_addr];
    end

    assign sts.r_zero  = (rsq_reg == '0);
    assign sts.norm_ok = (nrm_reg[65:62] == '0) && (nrm_reg[61:60] != '0);

    // operand selection
    always_comb
    begin
        r_sel   = r_reg[cmd.comp];
        v_sel   = v_reg[cmd.comp];
        u_sel   = u_reg[cmd.comp];
        w_sel   = w_reg[cmd.comp];
        r_mag   = 33'(mag41(41'(r_sel)));
        v_mag   = 33'(mag41(41'(v_sel)));
        u_mag   = 33'(mag41(41'(u_sel)));
        w_mag   = mag41(w_sel);
        dot_mag = mag41(41'(dot_reg));
        mul_a   = '0;
        mul_b   = '0;
        neg     = 1'b0;
        case (cmd.op)
            hfjap_pkg::OP_SQ:
            begin
                mul_a = 41'(r_mag);
                mul_b = r_mag;
            end
            hfjap_pkg::OP_NEWT_SQ:
            begin
                mul_a = 41'(y_reg);
                mul_b = 33'(y_reg);
            end
            hfjap_pkg::OP_NEWT_Q:
            begin
                mul_a = 41'(xm_reg);
                mul_b = 33'(y2_reg);
            end
            hfjap_pkg::OP_NEWT_Y:
            begin
                mul_a = 41'(t_reg);
                mul_b = 33'(y_reg);
            end
            hfjap_pkg::OP_CUBE:
            begin
                mul_a = 41'(y2_reg);
                mul_b = 33'(y_reg);
            end
            hfjap_pkg::OP_MASS:
            begin
                mul_a = 41'(mj_reg);
                mul_b = 33'(y3_reg);
            end
            hfjap_pkg::OP_UNIT:
            begin
                mul_a = 41'(r_mag);
                mul_b = 33'(y_reg);
                neg   = r_sel[32];
            end
            hfjap_pkg::OP_DOT:
            begin
                mul_a = 41'(v_mag);
                mul_b = u_mag;
                neg   = u_sel[32] ^ v_sel[32];
            end
            hfjap_pkg::OP_WVEC:
            begin
                mul_a = dot_mag;
                mul_b = u_mag;
                neg   = dot_reg[35] ^ u_sel[32];
            end
            hfjap_pkg::OP_ACC:
            begin
                mul_a = 41'(r_mag);
                mul_b = my_reg;
                neg   = r_sel[32];
            end
            hfjap_pkg::OP_JERK:
            begin
                mul_a = w_mag;
                mul_b = my_reg;
                neg   = w_sel[40];
            end
            default:
            begin
                neg = 1'b0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // unit vector shift is 31+s, force terms 58+3s; the offset of 32 allows left shifts
    assign s_ext    = 8'(s_reg);
    assign unit_amt = 8'sd63 + s_ext;
    assign term_amt = 8'sd90 + s_ext + s_ext + s_ext;
    assign shf_amt  = ((cmd.op == hfjap_pkg::OP_ACC) || (cmd.op == hfjap_pkg::OP_JERK)) ?
                      term_amt[6:0] : unit_amt[6:0];
    assign shf_out  = {prod, 32'b0} >> shf_amt;

    assign unit_over = (|shf_out[105:32]) || (shf_out[31] && (|shf_out[30:0]));
    assign unit_mag  = unit_over ? 33'h0_8000_0000 : shf_out[32:0];
    assign unit_val  = neg ? -$signed(unit_mag) : $signed(unit_mag);

    assign term_over = |shf_out[105:47];
    assign term_mag  = term_over ? '1 : shf_out[46:0];
    assign term_pos  = $signed(ACC_W'(term_mag));
    assign term_val  = neg ? -term_pos : term_pos;

    assign dot_term = $signed(36'(prod[63:30]));
    assign dot_val  = neg ? -dot_term : dot_term;

    assign p3     = {2'b0, prod} + {1'b0, prod, 1'b0};
    assign w_term = $signed(p3[70:30]);
    assign w_val  = 41'(v_sel) - (neg ? -w_term : w_term);

    assign q_val = prod[63:30];
    assign t_val = (q_val < THREE_Q31) ? 33'(THREE_Q31 - q_val) : '0;

    assign y_raw = prod[73:32];
    assign y_val = (y_raw > 42'h0_8000_0000) ? 32'h8000_0000 : y_raw[31:0];

    always_comb
    begin
        any_clamp = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            acc_cl[c] = clamp48(acc_reg[c]);
            jrk_cl[c] = clamp48(jrk_reg[c]);
            any_clamp = any_clamp | acc_cl[c][48] | jrk_cl[c][48];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            hfjap_pkg::OP_LOAD_SELF:
            begin
                self_pos_reg <= row_reg.pos;
                self_vel_reg <= row_reg.vel;
                sat_reg      <= 1'b0;
                for (int c = 0; c < 3; c++)
                begin
                    acc_reg[c] <= '0;
                    jrk_reg[c] <= '0;
                end
            end
            hfjap_pkg::OP_DIFF:
            begin
                mj_reg <= row_reg.mass;
                for (int c = 0; c < 3; c++)
                begin
                    r_reg[c] <= 33'($signed(row_reg.pos[c])) - 33'($signed(self_pos_reg[c]));
                    v_reg[c] <= 33'($signed(row_reg.vel[c])) - 33'($signed(self_vel_reg[c]));
                end
            end
            hfjap_pkg::OP_SQ:
            begin
                rsq_reg <= ((cmd.comp == 2'd0) ? 66'd0 : rsq_reg) + 66'(prod[64:0]);
            end
            hfjap_pkg::OP_ZERO_HIT:
            begin
                sat_reg <= 1'b1;
            end
            hfjap_pkg::OP_NORM_INIT:
            begin
                nrm_reg <= rsq_reg;
                s_reg   <= '0;
            end
            hfjap_pkg::OP_NORM_STEP:
            begin
                // two bits a step until the square lies in [2^60, 2^62)
                if (nrm_reg[65:62] != '0)
                begin
                    nrm_reg <= nrm_reg >> 2;
                    s_reg   <= s_reg + 6'sd1;
                end
                else if (nrm_reg[61:60] == '0)
                begin
                    nrm_reg <= nrm_reg << 2;
                    s_reg   <= s_reg - 6'sd1;
                end
                else
                begin
                    xm_reg <= nrm_reg[61:30];
                    y_reg  <= hfjap_pkg::seed_lookup(nrm_reg[61:58]);
                end
            end
            hfjap_pkg::OP_NEWT_SQ:  y2_reg <= prod[62:31];
            hfjap_pkg::OP_NEWT_Q:   t_reg  <= t_val;
            hfjap_pkg::OP_NEWT_Y:   y_reg  <= y_val;
            hfjap_pkg::OP_CUBE:     y3_reg <= prod[62:31];
            hfjap_pkg::OP_MASS:     my_reg <= prod[63:31];
            hfjap_pkg::OP_UNIT:
            begin
                u_reg[cmd.comp] <= unit_val;
                if (unit_over)
                    sat_reg <= 1'b1;
            end
            hfjap_pkg::OP_DOT:
            begin
                dot_reg <= ((cmd.comp == 2'd0) ? 36'sd0 : dot_reg) + dot_val;
            end
            hfjap_pkg::OP_WVEC:
            begin
                w_reg[cmd.comp] <= w_val;
            end
            hfjap_pkg::OP_ACC:
            begin
                acc_reg[cmd.comp] <= acc_reg[cmd.comp] + term_val;
                if (term_over)
                    sat_reg <= 1'b1;
            end
            hfjap_pkg::OP_JERK:
            begin
                jrk_reg[cmd.comp] <= jrk_reg[cmd.comp] + term_val;
                if (term_over)
                    sat_reg <= 1'b1;
            end
            hfjap_pkg::OP_EMIT:
            begin
                body_index  <= cmd.index;
                last_result <= cmd.last;
                acc_x       <= $signed(acc_cl[0][47:0]);
                acc_y       <= $signed(acc_cl[1][47:0]);
                acc_z       <= $signed(acc_cl[2][47:0]);
                jerk_x      <= $signed(jrk_cl[0][47:0]);
                jerk_y      <= $signed(jrk_cl[1][47:0]);
                jerk_z      <= $signed(jrk_cl[2][47:0]);
                saturated   <= sat_reg | any_clamp;
            end
            default:
            begin
                sat_reg <= sat_reg;
            end
        endcase
    end

endmodule

// ===== design/hermite_force_jerk_all_pairs_unit.sv =====
// ----------------------------------------------------------------------------
// hermite_force_jerk_all_pairs_unit
// direct-summation gravitational acceleration and jerk over a loaded body set
// ----------------------------------------------------------------------------
// usage
//   load: one item per accepted start (start high while busy is low). each item
//     holds position, velocity and mass of one body; items beyond MAX_BODIES
//     are dropped. an item with last_body set closes the set.
//   compute: busy rises after the closing item. for every body i, every other
//     body j runs through one shared multiplier in a fixed step sequence,
//     plus a two-bit normalizing shift of |r|^2 that repeats until the square
//     is in range; a coincident pair skips the steps after its zero check, and
//     each body adds its own read and emit steps. the sequential pair loop sets
//     the total run time.
//   results: one item per body in load order on the result ports, marked by
//     result_valid for exactly one cycle; last_result flags the final one and
//     busy is low in that cycle. the receiver cannot stall, each result must be
//     taken in the cycle it is shown.
//   reset: rst_n clears the body count and the sequencer; the body memory keeps
//     no reset and only rows of the current set are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hermite_force_jerk_all_pairs_unit #(
    parameter int MAX_BODIES = hfjap_pkg::MAX_BODIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [31:0]        mass,
    input  logic               last_body,
    output logic               result_valid,
    output logic [3:0]         body_index,
    output logic signed [47:0] acc_x,
    output logic signed [47:0] acc_y,
    output logic signed [47:0] acc_z,
    output logic signed [47:0] jerk_x,
    output logic signed [47:0] jerk_y,
    output logic signed [47:0] jerk_z,
    output logic               saturated,
    output logic               last_result
);

    // command and status between sequencer and datapath
    hfjap_pkg::cmd_t               cmd;
    hfjap_pkg::sts_t               sts;
    logic                          mem_we;
    logic                          mem_re;
    logic [$clog2(MAX_BODIES)-1:0] wr_addr;
    logic [$clog2(MAX_BODIES)-1:0] rd_addr;

    // sequencer: body count, pair loop, result strobe
    hfjap_ctrl #(
        .MAX_BODIES (MAX_BODIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_body    (last_body),
        .busy         (busy),
        .result_valid (result_valid),
        .sts          (sts),
        .cmd          (cmd),
        .mem_we       (mem_we),
        .mem_re       (mem_re),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    // datapath: body memory, multiplier, inverse square root, sums
    hfjap_datapath #(
        .MAX_BODIES (MAX_BODIES)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .vel_z       (vel_z),
        .mass        (mass),
        .sts         (sts),
        .body_index  (body_index),
        .acc_x       (acc_x),
        .acc_y       (acc_y),
        .acc_z       (acc_z),
        .jerk_x      (jerk_x),
        .jerk_y      (jerk_y),
        .jerk_z      (jerk_z),
        .saturated   (saturated),
        .last_result (last_result)
    );

endmodule

// ===== design/hfjap_checker.sv =====
// ----------------------------------------------------------------------------
// hfjap_checker
// port-level checks of load, compute and result sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hermite_force_jerk_all_pairs_unit_assert.svh"

module hfjap_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_body,
    input logic result_valid,
    input logic last_result
);

    // closing item starts the evaluation
    `HFJAP_ASSERT_NEXT(a_close_busy, start && !busy && last_body, busy)
    // results other than the final one appear while computing
    `HFJAP_ASSERT_IMPL(a_mid_busy, result_valid && !last_result, busy)
    // the final result returns the block to loading
    `HFJAP_ASSERT_IMPL(a_last_idle, result_valid && last_result, !busy)
    // strobes are never back to back
    `HFJAP_ASSERT_NEXT(a_strobe_gap, result_valid, !result_valid)

endmodule

bind hermite_force_jerk_all_pairs_unit hfjap_checker u_hfjap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_body    (last_body),
    .result_valid (result_valid),
    .last_result  (last_result)
);

// ===== dv/tb_hermite_force_jerk_all_pairs_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hermite_force_jerk_all_pairs_unit
// self-checking bench for the all-pairs acceleration and jerk unit
// ----------------------------------------------------------------------------
// body sets are queued by an initial block and fed by a clocked driver over the
// start/busy handshake. every accepted item goes through a bit-exact fixed-point
// model of the pair sum, which queues the per-body results that a clocked
// monitor then compares, field by field, against the result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hermite_force_jerk_all_pairs_unit;

    localparam int          BODY_CAP  = hfjap_pkg::MAX_BODIES_DEF;
    localparam logic [63:0] UNIT_Q31  = 64'd1 << 31;
    localparam logic [63:0] WIDE_CAP  = 64'd1 << 62;
    localparam logic [63:0] TERM_CAP  = (64'd1 << 47) - 1;
    localparam longint      SUM_HI    = (64'sd1 <<< 47) - 1;
    localparam longint      SUM_LO    = -(64'sd1 <<< 47);
    localparam int          CYCLE_CAP = 3000000;

    // q1.31 seeds of 1/sqrt(x), own copy
    localparam logic [31:0] RSQRT_SEED [16] = '{
        32'd2147483648, 32'd2147483648, 32'd2147483648, 32'd2147483648,
        32'd2024667000, 32'd1831380000, 32'd1684625000, 32'd1568300000,
        32'd1473162000, 32'd1393471000, 32'd1325456000, 32'd1266517000,
        32'd1214800000, 32'd1168942000, 32'd1127914000, 32'd1090923000
    };

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic [31:0]        mass;
        bit                 last;
    } body_item_t;

    typedef struct {
        logic [3:0]         index;
        logic signed [47:0] acc [3];
        logic signed [47:0] jerk [3];
        bit                 sat;
        bit                 last;
    } force_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic [31:0]        mass;
    logic               last_body;
    logic               result_valid;
    logic [3:0]         body_index;
    logic signed [47:0] acc_x, acc_y, acc_z;
    logic signed [47:0] jerk_x, jerk_y, jerk_z;
    logic               saturated;
    logic               last_result;

    hermite_force_jerk_all_pairs_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .mass         (mass),
        .last_body    (last_body),
        .result_valid (result_valid),
        .body_index   (body_index),
        .acc_x        (acc_x),
        .acc_y        (acc_y),
        .acc_z        (acc_z),
        .jerk_x       (jerk_x),
        .jerk_y       (jerk_y),
        .jerk_z       (jerk_z),
        .saturated    (saturated),
        .last_result  (last_result)
    );

    // the bench's own copy of the loaded set
    longint        set_pos [BODY_CAP*3];
    longint        set_vel [BODY_CAP*3];
    logic [63:0]   set_mass [BODY_CAP];
    int            set_count;

    body_item_t    load_queue [$];
    force_result_t expected_forces [$];
    int            mismatches;
    int            sender_idle_pct;
    int            cycle_count;
    body_item_t    cur_item;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [63:0] magnitude(input longint a);
        logic [63:0] m;
        m = a;
        if (a < 0)
            m = -m;
        return m;
    endfunction

    // sign(a*b) * min(|a*b| >> sh, cap), truncated magnitude
    function automatic longint scaled_product(input longint a, input longint b, input int sh,
                                              input logic [63:0] cap, inout bit sat);
        logic [127:0] p;
        logic [127:0] q;
        logic [63:0]  r;
        bit           neg;
        bit           over;
        neg = (a < 0) != (b < 0);
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        if (sh >= 0)
        begin
            q = p >> sh;
            over = q > {64'd0, cap};
            r = q[63:0];
        end
        else
        begin
            over = p > {64'd0, cap >> (-sh)};
            r = p[63:0] << (-sh);
        end
        if (over)
        begin
            r = cap;
            sat = 1'b1;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // adds the pull of body j on body i
    task automatic add_pair(input int i, input int j, inout longint acc [3],
                            inout longint jrk [3], inout bit sat);
        longint       r [3];
        longint       v [3];
        longint       u [3];
        longint       dot;
        longint       w;
        logic [127:0] dist_sq;
        logic [63:0]  m, xm, y, y2, q, t, y3, my;
        int           len, s, k;
        dot = 0;
        dist_sq = '0;
        for (int c = 0; c < 3; c++)
        begin
            r[c] = set_pos[j*3+c] - set_pos[i*3+c];
            v[c] = set_vel[j*3+c] - set_vel[i*3+c];
            dist_sq += {64'd0, magnitude(r[c])} * {64'd0, magnitude(r[c])};
        end
        if (dist_sq == 0)
        begin
            sat = 1'b1;
            return;
        end
        len = 0;
        for (int b = 127; b >= 0; b--)
            if (len == 0 && dist_sq[b])
                len = b + 1;
        s = (len + 1) / 2 - 31;
        if (s >= 0)
            m = 64'(dist_sq >> (2 * s));
        else
            m = dist_sq[63:0] << (-2 * s);
        xm = m >> 30;
        y = RSQRT_SEED[xm[31:28]];
        for (int n = 0; n < 2; n++)
        begin
            y2 = (y * y) >> 31;
            q = (xm * y2) >> 30;
            t = (q < 3 * UNIT_Q31) ? 3 * UNIT_Q31 - q : 64'd0;
            y = (y * t) >> 32;
            if (y > UNIT_Q31)
                y = UNIT_Q31;
        end
        y3 = (((y * y) >> 31) * y) >> 31;
        my = (set_mass[j] * y3) >> 31;
        for (int c = 0; c < 3; c++)
        begin
            u[c] = scaled_product(r[c], longint'(y), 31 + s, UNIT_Q31, sat);
            dot += scaled_product(u[c], v[c], 30, WIDE_CAP, sat);
        end
        k = 58 + 3 * s;
        for (int c = 0; c < 3; c++)
        begin
            w = v[c] - scaled_product(3 * dot, u[c], 30, WIDE_CAP, sat);
            acc[c] += scaled_product(r[c], longint'(my), k, TERM_CAP, sat);
            jrk[c] += scaled_product(w, longint'(my), k, TERM_CAP, sat);
        end
    endtask

    function automatic logic [47:0] clamp_sum(input longint v, inout bit sat);
        if (v > SUM_HI)
        begin
            v = SUM_HI;
            sat = 1'b1;
        end
        else if (v < SUM_LO)
        begin
            v = SUM_LO;
            sat = 1'b1;
        end
        return v[47:0];
    endfunction

    // store one accepted body; a closing item queues the whole set of results
    task automatic load_body(input body_item_t it);
        force_result_t res;
        longint        acc [3];
        longint        jrk [3];
        bit            sat;
        if (set_count < BODY_CAP)
        begin
            for (int c = 0; c < 3; c++)
            begin
                set_pos[set_count*3+c] = it.pos[c];
                set_vel[set_count*3+c] = it.vel[c];
            end
            set_mass[set_count] = {32'd0, it.mass};
            set_count++;
        end
        if (!it.last)
            return;
        for (int i = 0; i < set_count; i++)
        begin
            acc = '{0, 0, 0};
            jrk = '{0, 0, 0};
            sat = 1'b0;
            for (int j = 0; j < set_count; j++)
                if (j != i)
                    add_pair(i, j, acc, jrk, sat);
            res.index = i[3:0];
            for (int c = 0; c < 3; c++)
            begin
                res.acc[c] = clamp_sum(acc[c], sat);
                res.jerk[c] = clamp_sum(jrk[c], sat);
            end
            res.sat = sat;
            res.last = (i + 1 == set_count);
            expected_forces.push_back(res);
        end
        set_count = 0;
    endtask

    // driver: hold the item until start meets busy low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            vel_x <= '0;
            vel_y <= '0;
            vel_z <= '0;
            mass <= '0;
            last_body <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                load_body(cur_item);
            if (!start || !busy)
            begin
                if (load_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    cur_item = load_queue.pop_front();
                    pos_x <= cur_item.pos[0];
                    pos_y <= cur_item.pos[1];
                    pos_z <= cur_item.pos[2];
                    vel_x <= cur_item.vel[0];
                    vel_y <= cur_item.vel[1];
                    vel_z <= cur_item.vel[2];
                    mass <= cur_item.mass;
                    last_body <= cur_item.last;
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each strobe is one result, checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_forces.size() == 0)
            begin
                report("unexpected result", {60'd0, body_index}, 64'd0);
            end
            else
            begin
                force_result_t e;
                e = expected_forces.pop_front();
                if (body_index !== e.index)
                    report("body_index", body_index, e.index);
                if (acc_x !== e.acc[0])
                    report("acc_x", acc_x, e.acc[0]);
                if (acc_y !== e.acc[1])
                    report("acc_y", acc_y, e.acc[1]);
                if (acc_z !== e.acc[2])
                    report("acc_z", acc_z, e.acc[2]);
                if (jerk_x !== e.jerk[0])
                    report("jerk_x", jerk_x, e.jerk[0]);
                if (jerk_y !== e.jerk[1])
                    report("jerk_y", jerk_y, e.jerk[1]);
                if (jerk_z !== e.jerk[2])
                    report("jerk_z", jerk_z, e.jerk[2]);
                if (saturated !== e.sat)
                    report("saturated", saturated, e.sat);
                if (last_result !== e.last)
                    report("last_result", last_result, e.last);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mix of full-range, small and extreme values so every bit toggles
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom_range(65535) - 32768;
            4, 5, 6: return ($urandom_range(1 << 24) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    function automatic body_item_t make_body(input bit last);
        body_item_t it;
        for (int c = 0; c < 3; c++)
        begin
            it.pos[c] = pick_word();
            it.vel[c] = pick_word();
        end
        case ($urandom_range(5))
            0:       it.mass = 32'hffff_ffff;
            1:       it.mass = 32'd0;
            default: it.mass = $urandom;
        endcase
        it.last = last;
        return it;
    endfunction

    function automatic body_item_t fixed_body(input logic [31:0] p, input logic [31:0] v,
                                              input logic [31:0] m, input bit last);
        body_item_t it;
        it.pos = '{p, p, p};
        it.vel = '{v, v, v};
        it.mass = m;
        it.last = last;
        return it;
    endfunction

    // random sets: mostly small, a few full, a few overfilled
    task automatic queue_random_sets(input int items);
        int n;
        while (items > 0)
        begin
            case ($urandom_range(19))
                0:       n = BODY_CAP;
                1:       n = BODY_CAP + $urandom_range(1, 2);
                2:       n = 1;
                default: n = $urandom_range(2, 6);
            endcase
            for (int b = 0; b < n; b++)
                load_queue.push_back(make_body(b == n - 1));
            items -= n;
        end
    endtask

    task automatic drain();
        while (load_queue.size() > 0 || expected_forces.size() > 0 || busy || start)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_phase [4];
        idle_phase = '{0, 77, 0, 31};
        mismatches = 0;
        cycle_count = 0;
        set_count = 0;
        sender_idle_pct = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // single body: zeros
        load_queue.push_back(fixed_body(32'h0001_0000, 32'h0, 32'hffff_ffff, 1'b1));
        // coincident pair
        load_queue.push_back(fixed_body(32'h0002_0000, 32'h0001_0000, 32'h8000_0000, 1'b0));
        load_queue.push_back(fixed_body(32'h0002_0000, 32'hffff_0000, 32'h8000_0000, 1'b1));
        // opposite position and velocity extremes
        load_queue.push_back(fixed_body(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b0));
        load_queue.push_back(fixed_body(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1));
        // heavy bodies one lsb apart, forces clamp
        load_queue.push_back(fixed_body(32'h0, 32'h7fff_ffff, 32'hffff_ffff, 1'b0));
        load_queue.push_back(fixed_body(32'h1, 32'h8000_0000, 32'hffff_ffff, 1'b1));
        // overfilled set: the seventeenth body is dropped but closes the set
        for (int b = 0; b <= BODY_CAP; b++)
            load_queue.push_back(make_body(b == BODY_CAP));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = idle_phase[ph];
            queue_random_sets(120);
            drain();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_forces.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
